FILE: rtl/positional_list_insert_delete_defines.svh
// Assertion macros used by the controller RTL of the positional list block.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define PLID_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication
`define PLID_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PLID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/plid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plid_pkg;

    // Element width and the widest position the cell row supports (8192 cells)
    localparam int DATA_W = 32;
    localparam int POS_W  = 13;

    // Cells per first-level read-out group
    localparam int GROUP = 16;

    // Command codes carried in tuser
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // What every cell does in the execute cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } t_cell_op;

    // Broadcast from the controller to the cell row
    typedef struct packed {
        t_cell_op            op;
        logic                tap;
        logic [POS_W-1:0]    pos;
        logic [DATA_W-1:0]   val;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: rtl/plid_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module plid_cell #(
    parameter int IDX = 0
) (
    input  wire                          i_clk,
    input  plid_pkg::t_cell_ctl          i_ctl,
    input  wire  [plid_pkg::DATA_W-1:0]  i_left,
    input  wire  [plid_pkg::DATA_W-1:0]  i_right,
    output logic [plid_pkg::DATA_W-1:0]  o_val,
    output logic [plid_pkg::DATA_W-1:0]  o_tap
);
    import plid_pkg::*;

    logic [DATA_W-1:0] r_val;
    logic              w_here;
    logic              w_above;

    // Position decode against this cell's fixed index
    assign w_here  = (i_ctl.pos == POS_W'(IDX));
    assign w_above = (i_ctl.pos <  POS_W'(IDX));

    // Shift up on insert, down on delete, hold otherwise
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            CELL_INSERT: begin
                if (w_here) begin
                    r_val <= i_ctl.val;
                end else if (w_above) begin
                    r_val <= i_left;
                end
            end
            CELL_DELETE: begin
                if (w_here || w_above) begin
                    r_val <= i_right;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_val = r_val;

    // Read-out tap: only the addressed cell drives its value
    assign o_tap = (i_ctl.tap && w_here) ? r_val : '0;

endmodule

`default_nettype wire

FILE: rtl/plid_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_insert_delete_defines.svh"

module plid_ctrl #(
    parameter int CAPACITY = 256,
    parameter int CW       = 9
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // command side
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  plid_pkg::t_cmd               i_cmd,
    input  wire  [CW-1:0]                i_pos,
    input  wire  [plid_pkg::DATA_W-1:0]  i_val,
    // cell row
    output plid_pkg::t_cell_ctl          o_ctl,
    input  wire  [plid_pkg::DATA_W-1:0]  i_tap,
    // result side
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [plid_pkg::DATA_W-1:0]  o_value,
    output logic [CW-1:0]                o_count,
    output plid_pkg::t_status            o_status
);
    import plid_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GATHER
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    t_cell_op           r_op;
    logic               r_tap;
    logic [POS_W-1:0]   r_pos;
    logic [DATA_W-1:0]  r_val;
    t_status            r_status;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_value;
    logic [CW-1:0]      r_out_count;
    t_status            r_out_status;

    logic               w_full;
    logic               w_accept;
    logic               w_out_free;
    t_status            n_status;
    t_cell_op           n_op;
    logic               n_tap;
    logic [CW-1:0]      n_pos;

    assign w_full     = (r_count == CW'(CAPACITY));
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Command check against the current count
    always_comb begin
        n_status = ST_OK;
        n_op     = CELL_HOLD;
        n_tap    = 1'b0;
        n_pos    = i_pos;
        unique case (i_cmd)
            CMD_APPEND: begin
                n_pos = r_count;
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_op = CELL_INSERT;
                end
            end
            CMD_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else if (i_pos > r_count) begin
                    n_status = ST_RANGE;
                end else begin
                    n_op = CELL_INSERT;
                end
            end
            CMD_DELETE, CMD_READ: begin
                if (i_pos >= r_count) begin
                    n_status = ST_RANGE;
                end else begin
                    n_tap = 1'b1;
                    if (i_cmd == CMD_DELETE) begin
                        n_op = CELL_DELETE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, element count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_op        <= CELL_HOLD;
            r_tap       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // gather reloads the result register itself
            if (r_out_valid && i_out_ready && (r_state != S_GATHER)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= n_op;
                        r_tap    <= n_tap;
                        r_pos    <= POS_W'(n_pos);
                        r_val    <= i_val;
                        r_status <= n_status;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_op)
                        CELL_INSERT: r_count <= r_count + CW'(1);
                        CELL_DELETE: r_count <= r_count - CW'(1);
                        default: begin
                        end
                    endcase
                    r_state <= S_GATHER;
                end
                S_GATHER: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_value      <= r_tap ? i_tap : '0;
                        r_out_count  <= r_count;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Broadcast is live only in the execute cycle
    always_comb begin
        o_ctl.op  = (r_state == S_EXEC) ? r_op  : CELL_HOLD;
        o_ctl.tap = (r_state == S_EXEC) ? r_tap : 1'b0;
        o_ctl.pos = r_pos;
        o_ctl.val = r_val;
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_count     = r_out_count;
    assign o_status    = r_out_status;

    `PLID_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(CAPACITY), "count beyond capacity")
    `PLID_ASSERT_IMPL(a_err_zero, r_out_valid && (r_out_status != ST_OK), r_value == '0, "error result carries data")
    `PLID_ASSERT_IMPL(a_full_count, r_out_valid && (r_out_status == ST_FULL), r_out_count == CW'(CAPACITY), "full status below capacity")
    `PLID_ASSERT_NEXT(a_ins_count, (r_state == S_EXEC) && (r_op == CELL_INSERT), r_count == $past(r_count) + CW'(1), "insert did not bump count")

endmodule

`default_nettype wire

FILE: rtl/positional_list_insert_delete.sv
// The result register is loaded in gather, after execute, and drives o_m_tvalid and o_m_tdata.
// The controller walks accept, execute, gather; no new command is taken until it is back in idle.
// Gather stalls while an earlier result still waits on the master side; input is held off.
// Execute shifts every cell at once and latches the addressed cell into the group taps.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending result.
// Cell contents are not cleared; entries at or above the count are never read.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_delete #(
    parameter int CAPACITY = 256,
    localparam int CW      = $clog2(CAPACITY + 1),
    localparam int IW      = ((CW + 32 + 7) / 8) * 8,
    localparam int OW      = ((32 + CW + 2 + 7) / 8) * 8
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_s_tvalid,
    output logic          o_s_tready,
    input  wire  [IW-1:0] i_s_tdata,   // position [CW-1:0], value_in [CW+31:CW]
    input  wire  [1:0]    i_s_tuser,   // cmd [1:0]
    output logic          o_m_tvalid,
    input  wire           i_m_tready,
    output logic [OW-1:0] o_m_tdata    // value_out [31:0], count, status
);
    import plid_pkg::*;

    localparam int NGRP = (CAPACITY + GROUP - 1) / GROUP;

    t_cell_ctl          w_ctl;
    logic [DATA_W-1:0]  w_val [CAPACITY];
    logic [DATA_W-1:0]  w_tap [CAPACITY];
    logic [DATA_W-1:0]  n_grp [NGRP];
    logic [DATA_W-1:0]  r_grp [NGRP];
    logic [DATA_W-1:0]  w_tap_all;
    logic [DATA_W-1:0]  w_value;
    logic [CW-1:0]      w_count;
    t_status            w_status;

    // Controller: count, command check, result register
    plid_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_cmd       (t_cmd'(i_s_tuser)),
        .i_pos       (i_s_tdata[CW-1:0]),
        .i_val       (i_s_tdata[CW +: DATA_W]),
        .o_ctl       (w_ctl),
        .i_tap       (w_tap_all),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_value     (w_value),
        .o_count     (w_count),
        .o_status    (w_status)
    );

    // Row of cells, each linked to both neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[i+1];
        end
        plid_cell #(
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_val   (w_val[i]),
            .o_tap   (w_tap[i])
        );
    end

    // First read-out level: OR of each group of taps
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < CAPACITY) begin
                    n_grp[g] = n_grp[g] | w_tap[g * GROUP + k];
                end
            end
        end
    end

    // Group registers load only in a tapping execute cycle and hold through gather stalls
    always_ff @(posedge i_clk) begin
        if (w_ctl.tap) begin
            for (int g = 0; g < NGRP; g++) begin
                r_grp[g] <= n_grp[g];
            end
        end
    end

    // Second level: OR of the registered groups
    always_comb begin
        w_tap_all = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_tap_all = w_tap_all | r_grp[g];
        end
    end

    assign o_m_tdata = OW'({w_status, w_count, w_value});

endmodule

`default_nettype wire
